[hw/rtl/rtpred_pkg.sv]
// Shared types and constants for the RTP payload locator with RED block walk.
package rtpred_pkg;

    // Output field width fixed by the result format
    localparam int OUT_W         = 11;
    // Header end is 12 + 4 * CC, at most 72
    localparam int HDR_END_W     = 7;
    // Start of the RED walk: header end + 4 + 4 * 16-bit extension length
    localparam int RS_W          = 19;

    localparam int MIN_PACKET    = 12;
    localparam int EXT_HDR_BYTES = 4;
    // Offset of the extension length low byte past the CSRC words
    localparam int EXT_LEN_POS   = 3;

    // Bit positions in the first header byte and in a RED block header
    localparam int FHB_X_BIT     = 4;
    localparam int FHB_P_BIT     = 5;
    localparam int RED_F_BIT     = 7;

    localparam logic [HDR_END_W-1:0] HDR_BASE     = 7'd12;
    localparam logic [1:0]           RTP_VERSION  = 2'd2;
    localparam logic [6:0]           RED_PT_RESET = 7'd127;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_VERSION  = 2'd2,
        ST_OVERRUN  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RED_WAIT    = 2'd0,
        RED_IN_HDR  = 2'd1,
        RED_DONE    = 2'd2
    } red_phase_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [OUT_W-1:0] payload_offset;
        logic [OUT_W-1:0] payload_length;
    } out_item_t;

    // Per-packet summary handed from the byte tracker to the result stages
    typedef struct packed {
        logic                 version_ok;
        logic                 x_bit;
        logic                 p_bit;
        logic                 red_hit;
        logic                 red_done;
        logic                 overlong;
        logic [HDR_END_W-1:0] hdr_end;
        logic [RS_W-1:0]      red_start;
        logic [7:0]           pad;
    } fin_info_t;

endpackage

[hw/rtl/rtpred_hdr_track.sv]
// Input register, per-byte header tracking and RED block walk, packet summary register.
module rtpred_hdr_track #(
    parameter int  MAX_PACKET = 2048,
    localparam int PW         = $clog2(MAX_PACKET + 1),
    localparam int CW         = PW + 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rtpred_pkg::in_item_t  in_data,
    input  logic                  cfg_write_en,
    input  logic [6:0]            cfg_write_data,
    output logic                  fin_valid,
    input  logic                  fin_ready,
    output rtpred_pkg::fin_info_t fin_info,
    output logic [PW-1:0]         fin_total,
    output logic [CW-1:0]         fin_consumed
);

    localparam int RS_W = rtpred_pkg::RS_W;
    localparam int HW   = rtpred_pkg::HDR_END_W;

    logic                   in_vld_reg;
    rtpred_pkg::in_item_t   in_reg;
    logic [6:0]             cfg_reg;

    logic [PW-1:0]          pos_reg, pos_next;
    logic [7:0]             fhb_reg, fhb_next;
    logic [6:0]             pt_reg, pt_next;
    logic [HW-1:0]          hdr_end_reg, hdr_end_next;
    logic [RS_W-1:0]        red_start_reg, red_start_next;
    rtpred_pkg::red_phase_t phase_reg, phase_next;
    logic [1:0]             idx_reg, idx_next;
    logic [CW-1:0]          consumed_reg, consumed_next;
    logic [1:0]             blen_hi_reg, blen_hi_next;
    logic [7:0]             prev_reg, prev_next;
    logic                   overlong_reg, overlong_next;

    logic                   fin_vld_reg;
    rtpred_pkg::fin_info_t  fin_info_reg;
    logic [PW-1:0]          fin_total_reg;
    logic [CW-1:0]          fin_consumed_reg;

    logic                   take;
    logic                   fin_load_ok;
    logic                   last_take;
    logic                   at_limit;
    logic                   q0;
    logic                   capture;
    logic                   walk;
    logic [7:0]             b;
    logic [HW-1:0]          hdr_end_new;
    logic [RS_W-1:0]        red_start_cap;

    // Handshake: a packet's last byte waits for the summary register to free up
    assign b           = in_reg.packet_byte;
    assign fin_load_ok = !fin_vld_reg || fin_ready;
    assign take        = in_vld_reg && (!in_reg.end_of_packet || fin_load_ok);
    assign last_take   = take && in_reg.end_of_packet;
    assign in_ready    = !in_vld_reg || take;

    // Position decodes
    assign at_limit      = (pos_reg == PW'(MAX_PACKET));
    assign q0            = (pos_reg == '0);
    assign hdr_end_new   = rtpred_pkg::HDR_BASE + {1'b0, b[3:0], 2'b00};
    assign capture       = !q0 && fhb_reg[rtpred_pkg::FHB_X_BIT]
                           && (pos_reg == PW'(hdr_end_reg) + PW'(rtpred_pkg::EXT_LEN_POS));
    assign red_start_cap = RS_W'(hdr_end_reg) + RS_W'(rtpred_pkg::EXT_HDR_BYTES)
                           + RS_W'({prev_reg, b, 2'b00});
    assign walk          = !q0 && !capture && (RS_W'(pos_reg) >= red_start_reg);

    // Update packet state for one byte
    always_comb
    begin
        pos_next       = pos_reg;
        fhb_next       = fhb_reg;
        pt_next        = pt_reg;
        hdr_end_next   = hdr_end_reg;
        red_start_next = red_start_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        consumed_next  = consumed_reg;
        blen_hi_next   = blen_hi_reg;
        prev_next      = prev_reg;
        overlong_next  = overlong_reg;

        if (at_limit)
        begin
            overlong_next = 1'b1;
        end
        else
        begin
            pos_next  = pos_reg + PW'(1);
            prev_next = b;
            if (q0)
            begin
                fhb_next       = b;
                hdr_end_next   = hdr_end_new;
                red_start_next = RS_W'(hdr_end_new);
            end
            if (pos_reg == PW'(1))
            begin
                pt_next = b[6:0];
            end
            // Extension length complete: restart the RED walk past the extension
            if (capture)
            begin
                red_start_next = red_start_cap;
                phase_next     = rtpred_pkg::RED_WAIT;
                idx_next       = '0;
                consumed_next  = '0;
                blen_hi_next   = '0;
            end
            if (walk)
            begin
                unique case (phase_reg)
                    rtpred_pkg::RED_WAIT:
                    begin
                        if (!b[rtpred_pkg::RED_F_BIT])
                        begin
                            consumed_next = consumed_reg + CW'(1);
                            phase_next    = rtpred_pkg::RED_DONE;
                        end
                        else
                        begin
                            consumed_next = consumed_reg + CW'(4);
                            idx_next      = 2'd1;
                            phase_next    = rtpred_pkg::RED_IN_HDR;
                        end
                    end
                    rtpred_pkg::RED_IN_HDR:
                    begin
                        if (idx_reg == 2'd2)
                        begin
                            blen_hi_next = b[1:0];
                        end
                        else if (idx_reg == 2'd3)
                        begin
                            consumed_next = consumed_reg + CW'({blen_hi_reg, b});
                            phase_next    = rtpred_pkg::RED_WAIT;
                        end
                        idx_next = idx_reg + 2'd1;
                    end
                    rtpred_pkg::RED_DONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (take)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    // RED payload type register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rtpred_pkg::RED_PT_RESET;
        end
        else if (cfg_write_en)
        begin
            cfg_reg <= cfg_write_data;
        end
    end

    // Packet state: advance per byte, clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fhb_reg       <= '0;
            pt_reg        <= '0;
            hdr_end_reg   <= '0;
            red_start_reg <= '0;
            phase_reg     <= rtpred_pkg::RED_WAIT;
            idx_reg       <= '0;
            consumed_reg  <= '0;
            blen_hi_reg   <= '0;
            prev_reg      <= '0;
            overlong_reg  <= 1'b0;
        end
        else if (last_take)
        begin
            pos_reg       <= '0;
            fhb_reg       <= '0;
            pt_reg        <= '0;
            hdr_end_reg   <= '0;
            red_start_reg <= '0;
            phase_reg     <= rtpred_pkg::RED_WAIT;
            idx_reg       <= '0;
            consumed_reg  <= '0;
            blen_hi_reg   <= '0;
            prev_reg      <= '0;
            overlong_reg  <= 1'b0;
        end
        else if (take)
        begin
            pos_reg       <= pos_next;
            fhb_reg       <= fhb_next;
            pt_reg        <= pt_next;
            hdr_end_reg   <= hdr_end_next;
            red_start_reg <= red_start_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            consumed_reg  <= consumed_next;
            blen_hi_reg   <= blen_hi_next;
            prev_reg      <= prev_next;
            overlong_reg  <= overlong_next;
        end
    end

    // Packet summary register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else if (last_take)
        begin
            fin_vld_reg <= 1'b1;
        end
        else if (fin_ready)
        begin
            fin_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_take)
        begin
            fin_info_reg.version_ok <= (fhb_next[7:6] == rtpred_pkg::RTP_VERSION);
            fin_info_reg.x_bit      <= fhb_next[rtpred_pkg::FHB_X_BIT];
            fin_info_reg.p_bit      <= fhb_next[rtpred_pkg::FHB_P_BIT];
            fin_info_reg.red_hit    <= (pt_next == cfg_reg);
            fin_info_reg.red_done   <= (phase_next == rtpred_pkg::RED_DONE);
            fin_info_reg.overlong   <= overlong_next;
            fin_info_reg.hdr_end    <= hdr_end_next;
            fin_info_reg.red_start  <= red_start_next;
            fin_info_reg.pad        <= b;
            fin_total_reg           <= pos_next;
            fin_consumed_reg        <= consumed_next;
        end
    end

    assign fin_valid    = fin_vld_reg;
    assign fin_info     = fin_info_reg;
    assign fin_total    = fin_total_reg;
    assign fin_consumed = fin_consumed_reg;

endmodule

[hw/rtl/rtpred_result_calc.sv]
// Two result stages: header and extension trim, then padding and RED trim into the output register.
module rtpred_result_calc #(
    parameter int  MAX_PACKET = 2048,
    localparam int PW         = $clog2(MAX_PACKET + 1),
    localparam int CW         = PW + 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fin_valid,
    output logic                  fin_ready,
    input  rtpred_pkg::fin_info_t fin_info,
    input  logic [PW-1:0]         fin_total,
    input  logic [CW-1:0]         fin_consumed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rtpred_pkg::out_item_t out_data
);

    localparam int RS_W  = rtpred_pkg::RS_W;
    localparam int OUT_W = rtpred_pkg::OUT_W;

    logic                  b1_vld_reg;
    rtpred_pkg::status_t   b1_status_reg;
    logic [PW-1:0]         b1_off_reg;
    logic [PW-1:0]         b1_len_reg;
    logic [CW:0]           b1_sub_reg;
    logic [CW-1:0]         b1_add_reg;
    logic                  b1_red_fail_reg;

    logic                  out_vld_reg;
    rtpred_pkg::out_item_t out_reg;

    logic                  out_load_ok;
    logic                  b1_adv;

    rtpred_pkg::status_t   status_early;
    logic [PW-1:0]         hdr_ext;
    logic                  hdr_over;
    logic [PW-1:0]         len0;
    logic                  has_ext;
    logic                  ext_over;
    logic [PW-1:0]         len_e;
    logic [PW-1:0]         off1;
    logic [PW-1:0]         len1;
    logic [7:0]            pad_eff;
    logic [CW:0]           sub_amt;
    logic [CW-1:0]         add_amt;

    logic                  trim_bad;
    rtpred_pkg::status_t   status_fin;
    logic [PW-1:0]         off_fin;
    logic [PW-1:0]         len_fin;

    // Stage handshake
    assign out_load_ok = !out_vld_reg || out_ready;
    assign b1_adv      = b1_vld_reg && out_load_ok;
    assign fin_ready   = !b1_vld_reg || out_load_ok;

    // First stage: status checks, skip header and extension
    assign hdr_ext  = PW'(fin_info.hdr_end);
    assign hdr_over = fin_info.overlong || (hdr_ext > fin_total);
    assign len0     = fin_total - hdr_ext;
    assign has_ext  = fin_info.x_bit && (RS_W'(fin_total) >=
                      RS_W'(fin_info.hdr_end) + RS_W'(rtpred_pkg::EXT_HDR_BYTES));
    assign ext_over = fin_info.red_start > RS_W'(fin_total);
    assign len_e    = PW'(RS_W'(fin_total) - fin_info.red_start);
    assign pad_eff  = fin_info.p_bit ? fin_info.pad : 8'd0;

    always_comb
    begin
        priority if (fin_total < PW'(rtpred_pkg::MIN_PACKET))
        begin
            status_early = rtpred_pkg::ST_SHORT;
        end
        else if (!fin_info.version_ok)
        begin
            status_early = rtpred_pkg::ST_VERSION;
        end
        else if (hdr_over)
        begin
            status_early = rtpred_pkg::ST_OVERRUN;
        end
        else
        begin
            status_early = rtpred_pkg::ST_OK;
        end
    end

    // Overrunning extension eats the rest of the packet
    always_comb
    begin
        priority if (!has_ext)
        begin
            off1 = hdr_ext;
            len1 = len0;
        end
        else if (ext_over)
        begin
            off1 = fin_total;
            len1 = '0;
        end
        else
        begin
            off1 = PW'(fin_info.red_start);
            len1 = len_e;
        end
    end

    // Amount trimmed from the tail and skipped at the front
    always_comb
    begin
        if (fin_info.red_hit)
        begin
            sub_amt = (CW + 1)'(pad_eff) + (CW + 1)'(fin_consumed);
            add_amt = fin_consumed;
        end
        else
        begin
            sub_amt = (CW + 1)'(pad_eff);
            add_amt = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
        end
        else if (fin_valid && fin_ready)
        begin
            b1_vld_reg <= 1'b1;
        end
        else if (out_load_ok)
        begin
            b1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid && fin_ready)
        begin
            b1_status_reg   <= status_early;
            b1_off_reg      <= off1;
            b1_len_reg      <= len1;
            b1_sub_reg      <= sub_amt;
            b1_add_reg      <= add_amt;
            b1_red_fail_reg <= fin_info.red_hit && !fin_info.red_done;
        end
    end

    // Second stage: padding and RED overrun, final offset and length
    assign trim_bad = (b1_sub_reg > (CW + 1)'(b1_len_reg)) || b1_red_fail_reg;
    assign off_fin  = b1_off_reg + PW'(b1_add_reg);
    assign len_fin  = b1_len_reg - PW'(b1_sub_reg);

    always_comb
    begin
        priority if (b1_status_reg != rtpred_pkg::ST_OK)
        begin
            status_fin = b1_status_reg;
        end
        else if (trim_bad)
        begin
            status_fin = rtpred_pkg::ST_OVERRUN;
        end
        else
        begin
            status_fin = rtpred_pkg::ST_OK;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (b1_adv)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_adv)
        begin
            out_reg.status <= status_fin;
            if (status_fin == rtpred_pkg::ST_OK)
            begin
                out_reg.payload_offset <= OUT_W'(off_fin);
                out_reg.payload_length <= OUT_W'(len_fin);
            end
            else
            begin
                out_reg.payload_offset <= '0;
                out_reg.payload_length <= '0;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

[hw/rtl/rtp_red_payload_locator_unit.sv]
// Top level of the RTP payload locator: byte tracker and result stages.
// Throughput: one packet byte per cycle, packets back to back with no gap, while the output is taken;
// output back-pressure can stall a packet's last byte. A packet's result passes from the input
// register through the packet summary, the trim stage and the output register.
// Reset clears all packet state and sets the RED payload type to 127.
module rtp_red_payload_locator_unit #(
    parameter int MAX_PACKET = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rtpred_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rtpred_pkg::out_item_t out_data,
    input  logic                  cfg_write_en,
    input  logic [6:0]            cfg_write_data
);

    localparam int PW = $clog2(MAX_PACKET + 1);
    localparam int CW = PW + 9;

    logic                  fin_valid;
    logic                  fin_ready;
    rtpred_pkg::fin_info_t fin_info;
    logic [PW-1:0]         fin_total;
    logic [CW-1:0]         fin_consumed;

    // Per-byte tracking
    rtpred_hdr_track #(
        .MAX_PACKET (MAX_PACKET)
    ) u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fin_valid      (fin_valid),
        .fin_ready      (fin_ready),
        .fin_info       (fin_info),
        .fin_total      (fin_total),
        .fin_consumed   (fin_consumed)
    );

    // Result computation
    rtpred_result_calc #(
        .MAX_PACKET (MAX_PACKET)
    ) u_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .fin_valid    (fin_valid),
        .fin_ready    (fin_ready),
        .fin_info     (fin_info),
        .fin_total    (fin_total),
        .fin_consumed (fin_consumed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    // Error results carry no offset or length
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != rtpred_pkg::ST_OK)
        |-> (out_data.payload_offset == '0) && (out_data.payload_length == '0))
        else $error("error result with nonzero offset or length");

    // With the output register empty nothing can hold back an input request
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register empty");

endmodule
